// ----- rtl/puc_pkg.sv -----
`default_nettype none

package puc_pkg;

  // Result queue between the caller logic and the output channel.
  localparam int ResFifoDepth = 4;

  typedef struct packed {
    logic [31:0] fill_count;
    logic        base_valid;
    logic [7:0]  base_symbol;
    logic        last;
  } result_t;

  // Up to two results are written into the queue per accepted item.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/puc_out_fifo.sv -----
`default_nettype none

module puc_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire puc_pkg::push_t  push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output puc_pkg::result_t     out_data_o
);
  import puc_pkg::*;

  localparam int PtrW = $clog2(ResFifoDepth);
  localparam int CntW = $clog2(ResFifoDepth + 1);

  result_t           mem [ResFifoDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              pop;

  assign out_valid_o = (count_r != '0);
  assign out_data_o  = mem[rd_ptr_r];
  assign pop         = out_valid_o && out_ready_i;
  // Room for the largest burst a single item can cause.
  assign room_o      = (count_r <= CntW'(ResFifoDepth - 2));

  always_comb begin
    wr_ptr_nxt = PtrW'(wr_ptr_r + PtrW'(push_i.count));
    rd_ptr_nxt = PtrW'(rd_ptr_r + PtrW'(pop));
    count_nxt  = CntW'(count_r + CntW'(push_i.count) - CntW'(pop));
  end

  always_ff @(posedge clk) begin
    if (push_i.count != 2'd0) begin
      mem[wr_ptr_r] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem[PtrW'(wr_ptr_r + 1'b1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pileup_unanimous_consensus.sv -----
// Unanimous pileup consensus caller.
//
// The in_ channel carries sorted pileup elements; in_tlast marks the
// end-of-stream item, which closes the open group and produces the tail
// fill result. The out_ channel carries results: a called base with the
// number of N positions before it (out_tuser high), or the tail fill
// (out_tuser low). out_tlast marks the last result caused by one input item.
// The cfg_ port writes min_border_dist, min_depth and reference_length; the
// user must write it only while the block is idle; no logic enforces this.
//
// Each element is evaluated in the cycle it is transferred and its results
// are written into a four-entry result queue. One element is accepted per
// cycle while in_tready is high; an end-of-stream item can produce two
// results, drained one per cycle as out_tready allows. in_tready drops
// when the queue cannot take two more results, so a stalled receiver holds
// back the input. Reset loads the register defaults, closes any group,
// restarts the fill position at zero and empties the queue.
`default_nettype none

module pileup_unanimous_consensus (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input elements.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // ref_id[15:0], ref_pos[47:16], insert_offset[63:48],
  // read_front_dist[79:64], read_back_dist[95:80], symbol[103:96]
  input  wire logic [103:0] in_tdata,
  input  wire logic         in_tlast,
  // Results.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fill_count[31:0], base_symbol[39:32]
  output logic [39:0]       out_tdata,
  // base_valid[0]
  output logic              out_tuser,
  output logic              out_tlast,
  // Configuration writes.
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);
  import puc_pkg::*;

  localparam logic [1:0]  CfgMinBorderDist = 2'd0;
  localparam logic [1:0]  CfgMinDepth      = 2'd1;
  localparam logic [1:0]  CfgRefLength     = 2'd2;
  localparam logic [15:0] BorderDefault    = 16'd10;
  localparam logic [15:0] DepthDefault     = 16'd5;
  localparam logic [15:0] KeptMax          = 16'hFFFF;

  logic [15:0] min_border_dist_r;
  logic [15:0] min_depth_r;
  logic [31:0] reference_length_r;

  logic        group_open_r,     group_open_nxt;
  logic [15:0] group_ref_id_r,   group_ref_id_nxt;
  logic [31:0] group_ref_pos_r,  group_ref_pos_nxt;
  logic [15:0] group_offset_r,   group_offset_nxt;
  logic [15:0] kept_count_r,     kept_count_nxt;
  logic [7:0]  kept_symbol_r,    kept_symbol_nxt;
  logic        symbols_differ_r, symbols_differ_nxt;
  logic [32:0] next_position_r,  next_position_nxt;

  logic        accept;
  logic [15:0] in_ref_id;
  logic [31:0] in_ref_pos;
  logic [15:0] in_offset;
  logic [15:0] in_front;
  logic [15:0] in_back;
  logic [7:0]  in_symbol;

  logic        call;
  logic        behind;
  logic [31:0] base_fill;
  logic [32:0] np_after_base;
  logic [34:0] d_np0, d_np1, d_pos1, tail_d;
  logic [31:0] tail_fill;
  logic        new_group;
  logic        keep;
  logic [15:0] start_kept;
  logic [7:0]  start_symbol;
  logic        start_differ;
  result_t     base_res, tail_res;
  push_t       push;
  result_t     out_res;

  assign in_ref_id  = in_tdata[15:0];
  assign in_ref_pos = in_tdata[47:16];
  assign in_offset  = in_tdata[63:48];
  assign in_front   = in_tdata[79:64];
  assign in_back    = in_tdata[95:80];
  assign in_symbol  = in_tdata[103:96];

  assign accept = in_tvalid && in_tready;

  always_comb begin
    // Closing the open group: a call needs a nonzero kept count even when
    // min_depth is zero.
    call = group_open_r && (kept_count_r != 16'd0) && (kept_count_r >= min_depth_r)
           && !symbols_differ_r && (group_offset_r == 16'd0);
    behind    = (next_position_r < {1'b0, group_ref_pos_r});
    base_fill = behind ? (group_ref_pos_r - next_position_r[31:0]) : 32'd0;
    np_after_base = behind ? 33'({1'b0, group_ref_pos_r} + 33'd1)
                           : 33'(next_position_r + 33'd1);

    // Tail distance for each way the position can end up, computed side by
    // side so no adder waits on another.
    d_np0  = {3'b000, reference_length_r} - {2'b00, next_position_r};
    d_np1  = (&next_position_r) ? {3'b000, reference_length_r}
                                : 35'(d_np0 - 35'd1);
    d_pos1 = {3'b000, reference_length_r} - {3'b000, group_ref_pos_r} - 35'd1;
    if (!call) begin
      tail_d = d_np0;
    end else if (behind) begin
      tail_d = d_pos1;
    end else begin
      tail_d = d_np1;
    end
    tail_fill = (!tail_d[34] && (tail_d != 35'd0)) ? tail_d[31:0] : 32'd0;

    new_group = !group_open_r || (in_ref_id != group_ref_id_r)
                || (in_ref_pos != group_ref_pos_r) || (in_offset != group_offset_r);
    keep = (in_front >= min_border_dist_r) && (in_back >= min_border_dist_r);
    start_kept   = new_group ? 16'd0 : kept_count_r;
    start_symbol = new_group ? 8'd0  : kept_symbol_r;
    start_differ = new_group ? 1'b0  : symbols_differ_r;

    base_res.fill_count  = base_fill;
    base_res.base_valid  = 1'b1;
    base_res.base_symbol = kept_symbol_r;
    base_res.last        = !in_tlast;
    tail_res.fill_count  = tail_fill;
    tail_res.base_valid  = 1'b0;
    tail_res.base_symbol = 8'd0;
    tail_res.last        = 1'b1;

    group_open_nxt     = group_open_r;
    group_ref_id_nxt   = group_ref_id_r;
    group_ref_pos_nxt  = group_ref_pos_r;
    group_offset_nxt   = group_offset_r;
    kept_count_nxt     = kept_count_r;
    kept_symbol_nxt    = kept_symbol_r;
    symbols_differ_nxt = symbols_differ_r;
    next_position_nxt  = next_position_r;
    push.count  = 2'd0;
    push.first  = base_res;
    push.second = tail_res;

    if (accept && in_tlast) begin
      group_open_nxt     = 1'b0;
      group_ref_id_nxt   = 16'd0;
      group_ref_pos_nxt  = 32'd0;
      group_offset_nxt   = 16'd0;
      kept_count_nxt     = 16'd0;
      kept_symbol_nxt    = 8'd0;
      symbols_differ_nxt = 1'b0;
      next_position_nxt  = 33'd0;
      if (call) begin
        push.count = 2'd2;
      end else begin
        push.count = 2'd1;
        push.first = tail_res;
      end
    end else if (accept) begin
      group_open_nxt    = 1'b1;
      group_ref_id_nxt  = in_ref_id;
      group_ref_pos_nxt = in_ref_pos;
      group_offset_nxt  = in_offset;
      if (new_group && call) begin
        push.count        = 2'd1;
        next_position_nxt = np_after_base;
      end
      kept_count_nxt     = start_kept;
      kept_symbol_nxt    = start_symbol;
      symbols_differ_nxt = start_differ;
      if (keep) begin
        if (start_kept == 16'd0) begin
          kept_symbol_nxt = in_symbol;
        end else if (in_symbol != start_symbol) begin
          symbols_differ_nxt = 1'b1;
        end
        if (start_kept != KeptMax) begin
          kept_count_nxt = 16'(start_kept + 16'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_border_dist_r  <= BorderDefault;
      min_depth_r        <= DepthDefault;
      reference_length_r <= 32'd0;
      group_open_r       <= 1'b0;
      group_ref_id_r     <= 16'd0;
      group_ref_pos_r    <= 32'd0;
      group_offset_r     <= 16'd0;
      kept_count_r       <= 16'd0;
      kept_symbol_r      <= 8'd0;
      symbols_differ_r   <= 1'b0;
      next_position_r    <= 33'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CfgMinBorderDist: min_border_dist_r  <= cfg_wdata[15:0];
          CfgMinDepth:      min_depth_r        <= cfg_wdata[15:0];
          CfgRefLength:     reference_length_r <= cfg_wdata;
          default: ;
        endcase
      end
      group_open_r     <= group_open_nxt;
      group_ref_id_r   <= group_ref_id_nxt;
      group_ref_pos_r  <= group_ref_pos_nxt;
      group_offset_r   <= group_offset_nxt;
      kept_count_r     <= kept_count_nxt;
      kept_symbol_r    <= kept_symbol_nxt;
      symbols_differ_r <= symbols_differ_nxt;
      next_position_r  <= next_position_nxt;
    end
  end

  puc_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .room_o      (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_res)
  );

  assign out_tdata = {out_res.base_symbol, out_res.fill_count};
  assign out_tuser = out_res.base_valid;
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire

// ----- rtl/puc_checker.sv -----
`default_nettype none

module puc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         in_tlast,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [39:0]  out_tdata,
  input wire logic         out_tuser,
  input wire logic         out_tlast
);

  // Reset empties the result queue and leaves room for a new element.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("result queue not empty after reset");

  // A tail fill result is always the last one of its item and has no symbol.
  a_tail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && (out_tdata[39:32] == 8'd0)))
    else $error("tail fill result malformed");

  // An end-of-stream transfer always produces at least the tail result.
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("end of stream produced no result");

  // A base result that is not last must be followed by its tail.
  a_base_then_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser && !out_tlast) |=>
      (out_tvalid && !out_tuser))
    else $error("base result without following tail");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind pileup_unanimous_consensus puc_checker u_puc_checker (.*);

`default_nettype wire
